### design/weighted_inversion_sum_macros.svh
// Assertion macros used by the weighted inversion sum checker.
`ifndef WEIGHTED_INVERSION_SUM_MACROS_SVH
`define WEIGHTED_INVERSION_SUM_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define WIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define WIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wis_pkg.sv
// Shared constants, controller states and command/status types.
`timescale 1ns / 1ps
package wis_pkg;

  localparam int MAX_ITEMS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic drop;
    logic rd_issue;
    logic store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic last;
    logic out_busy;
  } status_t;

endpackage

### design/wis_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### design/wis_ctrl.sv
// Sequencer: accepts beats, walks the history scan, stores and emits results.
`timescale 1ns / 1ps
module wis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  wis_pkg::status_t stat,
  output wis_pkg::cmd_t    cmd
);
  import wis_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (stat.full) begin
            cmd.drop  = 1'b1;
            state_nxt = ST_EMIT;
          end else if (stat.empty) begin
            state_nxt = ST_STORE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = stat.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // a dropped beat without tlast lands here too and leaves at once
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/wis_dp.sv
// Datapath: item registers, history scan compare, running sum, output register.
`timescale 1ns / 1ps
module wis_dp #(
  parameter int MAX_ITEMS  = wis_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = wis_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [wis_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wis_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  input  wis_pkg::cmd_t                  cmd,
  output wis_pkg::status_t               stat
);
  import wis_pkg::*;

  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  logic [VALUE_BITS-1:0] value_in;
  logic [VALUE_BITS-1:0] value_r;
  logic                  last_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      idx_r;
  logic [OUT_DATA_W-1:0] sum_r;
  logic [OUT_DATA_W-1:0] sum_nxt;
  logic                  drop_r;
  logic                  rd_vld_r;
  logic [VALUE_BITS-1:0] rd_data;
  logic [OUT_DATA_W-1:0] total_r;
  logic                  ovf_r;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] value_ext;

  generate
    if (VALUE_BITS <= IN_DATA_W) begin : g_narrow
      assign value_in = in_tdata[VALUE_BITS-1:0];
    end else begin : g_wide
      assign value_in = {{(VALUE_BITS-IN_DATA_W){in_tdata[IN_DATA_W-1]}}, in_tdata};
    end
  endgenerate

  assign value_ext = {{(OUT_DATA_W-VALUE_BITS){value_r[VALUE_BITS-1]}}, value_r};

  wis_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (value_r),
    .rd_en   (cmd.rd_issue),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // each stored value greater than the new one adds the new value once
  always_comb begin
    sum_nxt = sum_r;
    if (rd_vld_r && ($signed(rd_data) > $signed(value_r))) begin
      sum_nxt = sum_r + value_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value_in;
      last_r  <= in_tlast;
    end
    if (cmd.emit) begin
      total_r <= sum_r;
      ovf_r   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      sum_r     <= '0;
      drop_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      sum_r    <= sum_nxt;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.rd_issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.store) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.emit) begin
        count_r   <= '0;
        sum_r     <= '0;
        drop_r    <= 1'b0;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign stat.full      = (count_r == CNT_W'(MAX_ITEMS));
  assign stat.empty     = (count_r == '0);
  assign stat.scan_last = ((idx_r + 1'b1) == count_r);
  assign stat.last      = last_r;
  assign stat.out_busy  = out_vld_r && !out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = total_r;
  assign out_tuser  = ovf_r;

endmodule

### design/weighted_inversion_sum.sv
// Top level of the weighted inversion sum block.
// Each value beat is compared with every value stored earlier in the same
// sequence; for each stored value that is strictly greater, the new value is
// added to a 64-bit running sum (wrapping). The beat with in_tlast returns the
// sum on out_tdata and the capacity flag on out_tuser, then the sequence is
// cleared. A beat walks the n values already stored in the history RAM, one
// entry per cycle on its single read port, and then stores its own value; a
// final beat goes on to an emit state that loads the output register,
// and stalls there for as long as an earlier result is still held unaccepted
// on the output. Beats beyond MAX_ITEMS in a sequence skip the scan (a final
// one waits on the output register the same way), are not stored and set the
// overflow flag. The result waits in an output register while the next
// sequence is already accepted.
`timescale 1ns / 1ps
module weighted_inversion_sum #(
  parameter int MAX_ITEMS  = wis_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = wis_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wis_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wis_pkg::OUT_DATA_W-1:0] out_tdata,  // [63:0] total
  output logic                           out_tuser   // [0] overflow
);
  import wis_pkg::*;

  cmd_t    cmd;
  status_t stat;

  wis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wis_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

### design/wis_checker.sv
// Port-level checks for the weighted inversion sum block, bound to the top.
`timescale 1ns / 1ps
`include "weighted_inversion_sum_macros.svh"
module wis_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [wis_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wis_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);

  `WIS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result beat changed")
  `WIS_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input taken right after a final beat")
  `WIS_ASSERT_NEXT(a_no_result_mid_seq, in_tvalid && in_tready && !in_tlast && !out_tvalid, !out_tvalid, "result without a final beat")
  `WIS_ASSERT_SAME(a_ready_on_result, $rose(out_tvalid), in_tready, "not ready for a new sequence when result appears")

endmodule

bind weighted_inversion_sum wis_checker u_wis_checker (.*);

### tb/tb_weighted_inversion_sum.sv
// Self-checking testbench for weighted_inversion_sum: streamed sequences vs. a local predictor.
`timescale 1ns / 1ps
module tb_weighted_inversion_sum;

  localparam int SEQ_CAP     = wis_pkg::MAX_ITEMS_DEF;
  localparam int VAL_BITS    = wis_pkg::VALUE_BITS_DEF;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int RANDOM_BEATS = 556;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } beat_t;

  typedef struct {
    logic [63:0] total;
    logic        overflow;
  } total_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [wis_pkg::IN_DATA_W-1:0]  in_tdata = '0;    // [31:0] value
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [wis_pkg::OUT_DATA_W-1:0] out_tdata;        // [63:0] total
  logic                           out_tuser;        // [0] overflow

  beat_t  beat_queue[$];
  total_t pending_totals[$];
  longint seen_values[$];
  logic [63:0] predicted_sum = '0;
  logic        predicted_drop = 1'b0;

  int error_count   = 0;
  int beats_sent    = 0;
  int totals_seen   = 0;
  int overflow_seqs = 0;
  int seq_count     = 0;
  int idle_cycles   = 0;

  weighted_inversion_sum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint widen(logic [31:0] raw);
    longint w;
    w = longint'(signed'(raw));
    w = (w <<< (64 - VAL_BITS)) >>> (64 - VAL_BITS);
    return w;
  endfunction

  // predictor: one accepted value beat
  task automatic absorb_value(logic [31:0] raw, logic fin);
    longint v;
    longint greater;
    total_t t;
    v = widen(raw);
    greater = 0;
    if (seen_values.size() < SEQ_CAP) begin
      foreach (seen_values[i])
        if (seen_values[i] > v) greater++;
      predicted_sum = predicted_sum + 64'(v * greater);
      seen_values.push_back(v);
    end else begin
      predicted_drop = 1'b1;
    end
    if (fin) begin
      t.total    = predicted_sum;
      t.overflow = predicted_drop;
      pending_totals.push_back(t);
      seen_values.delete();
      predicted_sum  = '0;
      predicted_drop = 1'b0;
    end
  endtask

  task automatic check_total(logic [63:0] total, logic overflow);
    total_t exp_t;
    if (pending_totals.size() == 0) begin
      $error("unexpected result beat: total %0d overflow %0b", $signed(total), overflow);
      error_count++;
    end else begin
      exp_t = pending_totals.pop_front();
      totals_seen++;
      if (exp_t.overflow) overflow_seqs++;
      if (total !== exp_t.total) begin
        $error("total: expected %0d, got %0d", $signed(exp_t.total), $signed(total));
        error_count++;
      end
      if (overflow !== exp_t.overflow) begin
        $error("overflow: expected %0b, got %0b", exp_t.overflow, overflow);
        error_count++;
      end
    end
  endtask

  task automatic push_beat(logic [31:0] value, logic last);
    beat_t b;
    b.value = value;
    b.last  = last;
    beat_queue.push_back(b);
    if (last) seq_count++;
  endtask

  task automatic push_seq(logic [31:0] vals[$]);
    foreach (vals[i]) push_beat(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic [31:0] pick_value(int flavor);
    int k;
    case (flavor)
      0: return $urandom;
      1: return 32'($urandom_range(0, 8)) - 32'd4;
      2: begin
        k = $urandom_range(0, 4);
        case (k)
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
      default: return pick_value($urandom_range(0, 2));
    endcase
  endfunction

  // sender: bursts with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    beat_t b;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (beat_queue.size() > 0) begin
        b = beat_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= b.value;
        in_tlast  <= b.last;
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int stall_mode;
  int mode_left;
  int hold_left;
  int taken;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      taken      = 0;
      hold_done  = 1'b0;
    end else begin
      if (out_tvalid && out_tready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && taken >= 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) absorb_value(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_total(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: %0d cycles without a beat", idle_cycles);
          $display("tb_weighted_inversion_sum: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int n;
    int len;
    int flavor;
    n = 0;

    push_seq('{32'h7fff_ffff});
    push_seq('{32'h8000_0000});
    push_seq('{32'h7fff_ffff, 32'h8000_0000});
    push_seq('{32'h0, 32'h0, 32'h0});
    push_seq('{32'd3, 32'd2, 32'd1, 32'd0, -32'sd1, -32'sd2, -32'sd3});
    push_seq('{32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1, 32'h7fff_ffff});
    push_seq('{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000});

    while (n < RANDOM_BEATS) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      flavor = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) push_beat(pick_value(flavor), i == len - 1);
      n += len;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_queue.size() != 0 || in_tvalid || pending_totals.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d sequences, %0d beats, %0d totals checked (%0d with overflow)",
             seq_count, beats_sent, totals_seen, overflow_seqs);
    if (error_count == 0) begin
      $display("tb_weighted_inversion_sum: PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_weighted_inversion_sum: FAIL");
    end
    $finish;
  end

endmodule
